FILE: rtl/core/xenc_pkg.sv
// ----------------------------------------------------------------------------
// xenc_pkg
// Shared types, constants and helper functions of the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
package xenc_pkg;

	localparam int MAX_NOP_RUN_DEF = 63;
	localparam int NOP_CNT_W       = 6;
	localparam int CODE_BYTES      = 8;
	localparam int LEN_W           = 4;
	localparam int IDX_W           = 3;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = 1;
	localparam int QCNT_W          = 2;

	typedef enum logic [3:0] {
		OP_PUSH     = 4'd0,
		OP_POP      = 4'd1,
		OP_MEMBASE  = 4'd2,
		OP_MEMSIB   = 4'd3,
		OP_MOVE     = 4'd4,
		OP_SHIFT    = 4'd5,
		OP_LEASUM   = 4'd6,
		OP_LEADISP  = 4'd7,
		OP_ALUIMM   = 4'd8,
		OP_NOP      = 4'd9,
		OP_REX      = 4'd10
	} op_t;

	localparam logic [7:0] BYTE_REX_B    = 8'h41;
	localparam logic [7:0] BYTE_SIB_RSP  = 8'h24;
	localparam logic [7:0] BYTE_LEA      = 8'h8D;
	localparam logic [7:0] BYTE_MOVSXD   = 8'h63;
	localparam logic [7:0] BYTE_MOV      = 8'h89;
	localparam logic [7:0] BYTE_ESC      = 8'h0F;
	localparam logic [7:0] BYTE_MOVSX_B  = 8'hBE;
	localparam logic [7:0] BYTE_MOVSX_W  = 8'hBF;
	localparam logic [7:0] BYTE_SHIFT    = 8'hC1;
	localparam logic [7:0] BYTE_ALU_I8   = 8'h83;
	localparam logic [7:0] BYTE_ALU_I32  = 8'h81;
	localparam logic [7:0] BYTE_NOP1     = 8'h90;
	localparam logic [7:0] BYTE_OPSIZE   = 8'h66;
	localparam logic [7:0] BYTE_NOPL     = 8'h1F;
	localparam logic [4:0] PUSH_HI       = 5'b01010;
	localparam logic [4:0] POP_HI        = 5'b01011;

	localparam logic [1:0] MOD_IND  = 2'b00;
	localparam logic [1:0] MOD_D8   = 2'b01;
	localparam logic [1:0] MOD_D32  = 2'b10;
	localparam logic [1:0] MOD_REG  = 2'b11;
	localparam logic [2:0] RM_SIB   = 3'd4;
	localparam logic [2:0] RM_BP    = 3'd5;

	typedef struct packed {
		logic [3:0]  move_width;
		logic        sign_narrow;
		logic        has_displacement;
		logic        wide_operand;
		logic [2:0]  opcode_ext;
		logic [31:0] literal_value;
		logic [1:0]  scale_log2;
		logic [4:0]  index_reg;
		logic [4:0]  reg_b;
		logic [4:0]  reg_a;
		logic [3:0]  operation;
	} req_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [CODE_BYTES-1:0][7:0] code;
		logic [LEN_W-1:0]           len;
		logic                       refused;
		logic                       is_nop;
		logic [NOP_CNT_W-1:0]       nop_cnt;
	} desc_t;

	// register number 8..15 needs a rex extension bit
	function automatic logic reg_hi(input logic [4:0] r);
		return ~r[4] & r[3];
	endfunction

	function automatic logic [7:0] rex_byte(input logic w, input logic r,
		input logic x, input logic b);
		return {4'b0100, w, r, x, b};
	endfunction

	function automatic logic fits8(input logic [31:0] v);
		return (v[31:7] == '0) || (v[31:7] == '1);
	endfunction

	// byte of one nop chunk (chunk length 1..9)
	function automatic logic [7:0] nop_byte(input logic [3:0] chunk, input logic [3:0] pos);
		logic       pre;
		logic [3:0] eff;
		logic [3:0] p;
		logic [7:0] res;
		pre = (chunk == 4'd6) || (chunk == 4'd9);
		eff = pre ? chunk - 4'd1 : chunk;
		p   = pre ? pos - 4'd1 : pos;
		res = 8'h00;
		if (pre && pos == 4'd0) begin
			res = BYTE_OPSIZE;
		end else if (eff == 4'd1) begin
			res = BYTE_NOP1;
		end else if (eff == 4'd2) begin
			res = (p == 4'd0) ? BYTE_OPSIZE : BYTE_NOP1;
		end else begin
			case (p)
				4'd0: res = BYTE_ESC;
				4'd1: res = BYTE_NOPL;
				4'd2: begin
					case (eff)
						4'd4:    res = 8'h40;
						4'd5:    res = 8'h44;
						4'd7:    res = 8'h80;
						4'd8:    res = 8'h84;
						default: res = 8'h00;
					endcase
				end
				default: res = 8'h00;
			endcase
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/xenc_front.sv
// ----------------------------------------------------------------------------
// xenc_front
// Classifies one request into its fixed byte string, a refusal or a nop run.
// ----------------------------------------------------------------------------
module xenc_front import xenc_pkg::*; #(
	parameter int MAX_NOP_RUN = MAX_NOP_RUN_DEF
) (
	input  req_t  req,
	output desc_t desc
);

	localparam logic [NOP_CNT_W-1:0] MAX_CNT = NOP_CNT_W'(MAX_NOP_RUN);

	logic [CODE_BYTES-1:0][7:0] code;
	logic [LEN_W-1:0]           n;
	logic                       refused;
	logic                       is_nop;
	logic [NOP_CNT_W-1:0]       nop_cnt;
	logic [2:0]                 ra, rb, ri;
	logic                       ha, hb, hx;
	logic [1:0]                 mod;
	logic [31:0]                disp;
	logic                       plain;
	logic                       lit_pos;
	logic                       lit_over;

	assign ra = req.reg_a[2:0];
	assign rb = req.reg_b[2:0];
	assign ri = req.index_reg[2:0];
	assign ha = reg_hi(req.reg_a);
	assign hb = reg_hi(req.reg_b);
	assign hx = reg_hi(req.index_reg);
	assign plain = ~req.sign_narrow | (req.move_width >= 4'd8);

	assign lit_pos  = ~req.literal_value[31] & (req.literal_value != '0);
	assign lit_over = (req.literal_value[31:NOP_CNT_W] != '0) ||
		(req.literal_value[NOP_CNT_W-1:0] > MAX_CNT);

	always_comb begin
		code    = '0;
		n       = '0;
		refused = 1'b0;
		is_nop  = 1'b0;
		nop_cnt = '0;
		mod     = MOD_IND;
		disp    = req.literal_value;
		case (op_t'(req.operation))
			OP_PUSH, OP_POP: begin
				if (ha) begin
					code[n[IDX_W-1:0]] = BYTE_REX_B; n = n + 4'd1;
				end
				code[n[IDX_W-1:0]] = {(req.operation == OP_PUSH) ? PUSH_HI : POP_HI, ra};
				n = n + 4'd1;
			end
			OP_MEMBASE: begin
				// rbp/r13 base without displacement needs a zero disp8
				if (!req.has_displacement && rb == RM_BP) begin
					disp = '0;
				end
				if (req.has_displacement || rb == RM_BP) begin
					mod = fits8(disp) ? MOD_D8 : MOD_D32;
				end
				code[n[IDX_W-1:0]] = {mod, ra, rb}; n = n + 4'd1;
				if (rb == RM_SIB) begin
					code[n[IDX_W-1:0]] = BYTE_SIB_RSP; n = n + 4'd1;
				end
				if (mod == MOD_D8) begin
					code[n[IDX_W-1:0]] = disp[7:0]; n = n + 4'd1;
				end else if (mod == MOD_D32) begin
					code[n[IDX_W-1:0]] = disp[7:0];   n = n + 4'd1;
					code[n[IDX_W-1:0]] = disp[15:8];  n = n + 4'd1;
					code[n[IDX_W-1:0]] = disp[23:16]; n = n + 4'd1;
					code[n[IDX_W-1:0]] = disp[31:24]; n = n + 4'd1;
				end
			end
			OP_MEMSIB: begin
				if (disp != '0 || rb == RM_BP) begin
					mod = fits8(disp) ? MOD_D8 : MOD_D32;
				end
				code[n[IDX_W-1:0]] = {mod, ra, RM_SIB};            n = n + 4'd1;
				code[n[IDX_W-1:0]] = {req.scale_log2, ri, rb};     n = n + 4'd1;
				if (mod == MOD_D8) begin
					code[n[IDX_W-1:0]] = disp[7:0]; n = n + 4'd1;
				end else if (mod == MOD_D32) begin
					code[n[IDX_W-1:0]] = disp[7:0];   n = n + 4'd1;
					code[n[IDX_W-1:0]] = disp[15:8];  n = n + 4'd1;
					code[n[IDX_W-1:0]] = disp[23:16]; n = n + 4'd1;
					code[n[IDX_W-1:0]] = disp[31:24]; n = n + 4'd1;
				end
			end
			OP_MOVE: begin
				if (plain) begin
					// copy of a register onto itself encodes to nothing
					if (req.reg_a != req.reg_b) begin
						code[0] = rex_byte(1'b1, hb, 1'b0, ha);
						code[1] = BYTE_MOV;
						code[2] = {MOD_REG, rb, ra};
						n = 4'd3;
					end
				end else if (req.move_width == 4'd4) begin
					code[0] = rex_byte(1'b1, ha, 1'b0, hb);
					code[1] = BYTE_MOVSXD;
					code[2] = {MOD_REG, ra, rb};
					n = 4'd3;
				end else begin
					code[0] = rex_byte(1'b1, ha, 1'b0, hb);
					code[1] = BYTE_ESC;
					code[2] = (req.move_width == 4'd1) ? BYTE_MOVSX_B : BYTE_MOVSX_W;
					code[3] = {MOD_REG, ra, rb};
					n = 4'd4;
				end
			end
			OP_SHIFT: begin
				code[0] = rex_byte(1'b1, 1'b0, 1'b0, ha);
				code[1] = BYTE_SHIFT;
				code[2] = {MOD_REG, req.opcode_ext, ra};
				code[3] = disp[7:0];
				n = 4'd4;
			end
			OP_LEASUM: begin
				if (rb == RM_BP || ri == RM_SIB) begin
					refused = 1'b1;
				end else begin
					code[0] = rex_byte(1'b1, ha, hx, hb);
					code[1] = BYTE_LEA;
					code[2] = {MOD_IND, ra, RM_SIB};
					code[3] = {2'b00, ri, rb};
					n = 4'd4;
				end
			end
			OP_LEADISP: begin
				if (rb == RM_SIB) begin
					refused = 1'b1;
				end else begin
					code[0] = rex_byte(1'b1, ha, 1'b0, hb);
					code[1] = BYTE_LEA;
					code[2] = {fits8(disp) ? MOD_D8 : MOD_D32, ra, rb};
					code[3] = disp[7:0];
					code[4] = disp[15:8];
					code[5] = disp[23:16];
					code[6] = disp[31:24];
					n = fits8(disp) ? 4'd4 : 4'd7;
				end
			end
			OP_ALUIMM: begin
				code[0] = rex_byte(1'b1, 1'b0, 1'b0, ha);
				code[1] = fits8(disp) ? BYTE_ALU_I8 : BYTE_ALU_I32;
				code[2] = {MOD_REG, req.opcode_ext, ra};
				code[3] = disp[7:0];
				code[4] = disp[15:8];
				code[5] = disp[23:16];
				code[6] = disp[31:24];
				n = fits8(disp) ? 4'd4 : 4'd7;
			end
			OP_NOP: begin
				if (lit_pos) begin
					is_nop  = 1'b1;
					nop_cnt = lit_over ? MAX_CNT : disp[NOP_CNT_W-1:0];
				end
			end
			OP_REX: begin
				code[0] = rex_byte(req.wide_operand, ha, hx, hb);
				n = 4'd1;
			end
			default: begin
				n = '0;
			end
		endcase
	end

	always_comb begin
		desc.code    = code;
		desc.len     = (32'(n) > MAX_NOP_RUN) ? LEN_W'(MAX_NOP_RUN) : n;
		desc.refused = refused;
		desc.is_nop  = is_nop;
		desc.nop_cnt = nop_cnt;
	end

endmodule

FILE: rtl/core/xenc_queue.sv
// ----------------------------------------------------------------------------
// xenc_queue
// Two-entry request queue between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module xenc_queue import xenc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output desc_t head
);

	desc_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

FILE: rtl/core/xenc_back.sv
// ----------------------------------------------------------------------------
// xenc_back
// Walks a classified request and sends its bytes one per cycle unless stalled.
// ----------------------------------------------------------------------------
module xenc_back import xenc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  desc_t      q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	desc_t                cur_q;
	logic                 cur_valid_q;
	logic [IDX_W-1:0]     idx_q;
	logic [NOP_CNT_W-1:0] nop_rem_q;
	logic [3:0]           nop_pos_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic [1:0]           out_user_q;
	logic                 out_last_q;

	logic                 out_free;
	logic                 emit;
	logic [3:0]           chunk;
	logic                 chunk_end;
	logic [7:0]           e_byte;
	logic                 e_valid;
	logic                 e_last;
	logic                 load;

	assign out_free = ~out_valid_q | m_tready;
	assign emit     = cur_valid_q & out_free;
	assign chunk    = (nop_rem_q > NOP_CNT_W'(9)) ? 4'd9 : nop_rem_q[3:0];
	assign chunk_end = (nop_pos_q == chunk - 4'd1);

	always_comb begin
		if (cur_q.is_nop) begin
			e_byte  = nop_byte(chunk, nop_pos_q);
			e_valid = 1'b1;
			e_last  = chunk_end && (nop_rem_q == NOP_CNT_W'(chunk));
		end else if (cur_q.len == '0) begin
			e_byte  = 8'h00;
			e_valid = 1'b0;
			e_last  = 1'b1;
		end else begin
			e_byte  = cur_q.code[idx_q];
			e_valid = 1'b1;
			e_last  = ({1'b0, idx_q} == cur_q.len - 4'd1);
		end
	end

	// next request loads as the current one sends its last byte
	assign load  = q_valid & (~cur_valid_q | (emit & e_last));
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
			end else if (emit && e_last) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q     <= q_head;
			idx_q     <= '0;
			nop_rem_q <= q_head.nop_cnt;
			nop_pos_q <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
			if (chunk_end) begin
				nop_rem_q <= nop_rem_q - NOP_CNT_W'(chunk);
				nop_pos_q <= '0;
			end else begin
				nop_pos_q <= nop_pos_q + 4'd1;
			end
		end
		if (emit) begin
			out_byte_q <= e_byte;
			out_user_q <= {cur_q.refused & ~e_valid, e_valid};
			out_last_q <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/core/x86_64_instruction_encoder_top.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_top
// Encodes one request into x86-64 machine-code bytes, one byte per result.
// ----------------------------------------------------------------------------
//  side    group  payload                                           accepted at
//  in      s_*    tuser: operation / tdata: register, literal, flags s_tvalid & s_tready
//  out     m_*    tdata: code_byte / tuser: byte_valid, refused       m_tvalid & m_tready
//
// a request gives one result per byte, an empty one if it has none, one byte per cycle
// from the emitter unless stalled; requests follow with no gap thanks to a two-entry queue
// the front classifies in the accept cycle; then queue, emitter and output registers
// reset clears queue pointers, emitter and output valid; no clearing pass
// either side may stall on its own; s_tready drops only while the queue is full
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_top import xenc_pkg::*; #(
	parameter int MAX_NOP_RUN = MAX_NOP_RUN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// reg_a, reg_b, index_reg, scale_log2, literal_value, opcode_ext,
	// wide_operand, has_displacement, sign_narrow, move_width, zero fill
	input  logic [63:0] s_tdata,
	// operation
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// code_byte
	output logic [7:0]  m_tdata,
	// byte_valid, refused
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	req_t  req;
	desc_t desc;
	desc_t head;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;

	assign req = {s_tdata[58:0], s_tuser};
	assign s_tready = ~q_full;

	xenc_front #(
		.MAX_NOP_RUN(MAX_NOP_RUN)
	) u_front (
		.req  (req),
		.desc (desc)
	);

	xenc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_desc (desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head)
	);

	xenc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: tb/sv/xenc_encoding_checker.sv
// ----------------------------------------------------------------------------
// xenc_encoding_checker
// Watches both stream channels of the encoder, works out the machine-code
// bytes of every accepted request and compares each output byte against them.
// ----------------------------------------------------------------------------
module xenc_encoding_checker import xenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [3:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] code;
		logic       valid;
		logic       refused;
		logic       last;
	} code_res_t;

	code_res_t  pending_bytes[$];
	logic [7:0] enc_bytes[$];
	int         mismatches = 0;
	int         pending_cnt = 0;
	int         byte_no = 0;
	req_t       seen_req;
	code_res_t  want_res;
	code_res_t  seen_res;

	assign fail_count = mismatches;
	assign pending    = pending_cnt;

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", byte_no, msg);
		mismatches++;
	endtask

	function automatic bit fits_imm8(input int v);
		return (v >= -128) && (v <= 127);
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		enc_bytes.push_back(b);
	endfunction

	function automatic void put_dword(input logic [31:0] v);
		put_byte(v[7:0]);
		put_byte(v[15:8]);
		put_byte(v[23:16]);
		put_byte(v[31:24]);
	endfunction

	// negative register numbers never set an extension bit
	function automatic void put_rex(input bit w, input int rg, input int rm, input int ix);
		logic [7:0] r;
		r = 8'h40;
		if (w) r = r | 8'h08;
		if (rg >= 8) r = r | 8'h04;
		if (ix >= 8) r = r | 8'h02;
		if (rm >= 8) r = r | 8'h01;
		put_byte(r);
	endfunction

	function automatic void put_base_addr(input int rg, input int base, input int disp,
		input bit hd);
		logic [1:0] md;
		logic [2:0] b;
		b  = base[2:0];
		md = MOD_IND;
		// rbp/r13 base cannot go without a displacement
		if (!hd && b == RM_BP) begin
			hd   = 1'b1;
			disp = 0;
		end
		if (hd) md = fits_imm8(disp) ? MOD_D8 : MOD_D32;
		put_byte({md, rg[2:0], b});
		if (b == RM_SIB) put_byte(BYTE_SIB_RSP);
		if (md == MOD_D8) begin
			put_byte(disp[7:0]);
		end else if (md == MOD_D32) begin
			put_dword(disp);
		end
	endfunction

	function automatic void put_sib_addr(input int rg, input int base, input int ix,
		input logic [1:0] sc, input int disp);
		logic [1:0] md;
		md = MOD_IND;
		if (disp != 0 || base[2:0] == RM_BP) md = fits_imm8(disp) ? MOD_D8 : MOD_D32;
		put_byte({md, rg[2:0], RM_SIB});
		put_byte({sc, ix[2:0], base[2:0]});
		if (md == MOD_D8) begin
			put_byte(disp[7:0]);
		end else if (md == MOD_D32) begin
			put_dword(disp);
		end
	endfunction

	// padding in chunks of up to nine bytes, 6 and 9 get an operand-size prefix
	function automatic void put_nop_pad(input int n);
		int chunk;
		if (n > MAX_NOP_RUN_DEF) n = MAX_NOP_RUN_DEF;
		while (n > 0) begin
			chunk = (n > 9) ? 9 : n;
			n     = n - chunk;
			if (chunk == 6 || chunk == 9) begin
				put_byte(BYTE_OPSIZE);
				chunk--;
			end
			case (chunk)
				1: put_byte(BYTE_NOP1);
				2: begin
					put_byte(BYTE_OPSIZE);
					put_byte(BYTE_NOP1);
				end
				default: begin
					put_byte(BYTE_ESC);
					put_byte(BYTE_NOPL);
					case (chunk)
						3: put_byte(8'h00);
						4: begin
							put_byte(8'h40);
							put_byte(8'h00);
						end
						5: begin
							put_byte(8'h44);
							put_byte(8'h00);
							put_byte(8'h00);
						end
						7: begin
							put_byte(8'h80);
							put_dword(32'h0);
						end
						default: begin
							put_byte(8'h84);
							put_byte(8'h00);
							put_dword(32'h0);
						end
					endcase
				end
			endcase
		end
	endfunction

	function automatic void predict_encoding(input req_t rq);
		int ra;
		int rb;
		int ri;
		int lit;
		bit refused;
		ra      = $signed(rq.reg_a);
		rb      = $signed(rq.reg_b);
		ri      = $signed(rq.index_reg);
		lit     = $signed(rq.literal_value);
		refused = 1'b0;
		enc_bytes.delete();
		case (rq.operation)
			OP_PUSH, OP_POP: begin
				if (ra >= 8) put_byte(BYTE_REX_B);
				put_byte({((rq.operation == OP_PUSH) ? PUSH_HI : POP_HI), rq.reg_a[2:0]});
			end
			OP_MEMBASE: put_base_addr(ra, rb, lit, rq.has_displacement);
			OP_MEMSIB:  put_sib_addr(ra, rb, ri, rq.scale_log2, lit);
			OP_MOVE: begin
				if (!rq.sign_narrow || rq.move_width >= 4'd8) begin
					// copy onto itself needs no instruction
					if (ra != rb) begin
						put_rex(1'b1, rb, ra, -1);
						put_byte(BYTE_MOV);
						put_byte({MOD_REG, rb[2:0], ra[2:0]});
					end
				end else if (rq.move_width == 4'd4) begin
					put_rex(1'b1, ra, rb, -1);
					put_byte(BYTE_MOVSXD);
					put_byte({MOD_REG, ra[2:0], rb[2:0]});
				end else begin
					put_rex(1'b1, ra, rb, -1);
					put_byte(BYTE_ESC);
					put_byte((rq.move_width == 4'd1) ? BYTE_MOVSX_B : BYTE_MOVSX_W);
					put_byte({MOD_REG, ra[2:0], rb[2:0]});
				end
			end
			OP_SHIFT: begin
				put_rex(1'b1, -1, ra, -1);
				put_byte(BYTE_SHIFT);
				put_byte({MOD_REG, rq.opcode_ext, ra[2:0]});
				put_byte(lit[7:0]);
			end
			OP_LEASUM: begin
				if (rb[2:0] == RM_BP || ri[2:0] == RM_SIB) begin
					refused = 1'b1;
				end else begin
					put_rex(1'b1, ra, rb, ri);
					put_byte(BYTE_LEA);
					put_sib_addr(ra, rb, ri, 2'd0, 0);
				end
			end
			OP_LEADISP: begin
				if (rb[2:0] == RM_SIB) begin
					refused = 1'b1;
				end else begin
					put_rex(1'b1, ra, rb, -1);
					put_byte(BYTE_LEA);
					if (fits_imm8(lit)) begin
						put_byte({MOD_D8, ra[2:0], rb[2:0]});
						put_byte(lit[7:0]);
					end else begin
						put_byte({MOD_D32, ra[2:0], rb[2:0]});
						put_dword(lit);
					end
				end
			end
			OP_ALUIMM: begin
				put_rex(1'b1, -1, ra, -1);
				if (fits_imm8(lit)) begin
					put_byte(BYTE_ALU_I8);
					put_byte({MOD_REG, rq.opcode_ext, ra[2:0]});
					put_byte(lit[7:0]);
				end else begin
					put_byte(BYTE_ALU_I32);
					put_byte({MOD_REG, rq.opcode_ext, ra[2:0]});
					put_dword(lit);
				end
			end
			OP_NOP: put_nop_pad(lit);
			OP_REX: put_rex(rq.wide_operand, ra, rb, ri);
			default: ;
		endcase
		// a request with no bytes still yields one empty result
		if (enc_bytes.size() == 0) begin
			pending_bytes.push_back({8'h00, 1'b0, refused, 1'b1});
		end else begin
			foreach (enc_bytes[k]) begin
				pending_bytes.push_back({enc_bytes[k], 1'b1, 1'b0,
					(k == enc_bytes.size() - 1)});
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				// tdata fields sit right above the operation, same order as req_t
				seen_req = req_t'({s_tdata[58:0], s_tuser});
				predict_encoding(seen_req);
			end
			if (m_tvalid && m_tready) begin
				seen_res = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
				if (pending_bytes.size() == 0) begin
					report_mismatch($sformatf("result %02h valid %b refused %b last %b with no request",
						seen_res.code, seen_res.valid, seen_res.refused, seen_res.last));
				end else begin
					want_res = pending_bytes.pop_front();
					if (seen_res !== want_res) begin
						report_mismatch($sformatf(
							"got %02h/%b/%b/%b want %02h/%b/%b/%b (byte/valid/refused/last)",
							seen_res.code, seen_res.valid, seen_res.refused, seen_res.last,
							want_res.code, want_res.valid, want_res.refused, want_res.last));
					end
				end
				byte_no++;
			end
			pending_cnt = pending_bytes.size();
		end
	end

endmodule

FILE: tb/sv/tb_x86_64_instruction_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_x86_64_instruction_encoder_top
// Drives directed and random encoding requests into the encoder with random
// stalls on both sides and one long output hold-off; the checker predicts and
// compares every byte, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_x86_64_instruction_encoder_top;
	import xenc_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_TAIL   = 80;
	localparam int HOLD_AT      = 150;
	localparam int LONG_HOLD    = 400;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int          send_odds = 3;
	req_t        directed_q[$];

	x86_64_instruction_encoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	xenc_encoding_checker enc_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic req_t make_req(input op_t op, input int ra, input int rb, input int ix,
		input int sc, input int lit, input int ext, input bit wide, input bit hd,
		input bit narrow, input int mw);
		req_t r;
		r.operation        = op;
		r.reg_a            = 5'(ra);
		r.reg_b            = 5'(rb);
		r.index_reg        = 5'(ix);
		r.scale_log2       = 2'(sc);
		r.literal_value    = 32'(lit);
		r.opcode_ext       = 3'(ext);
		r.wide_operand     = wide;
		r.has_displacement = hd;
		r.sign_narrow      = narrow;
		r.move_width       = 4'(mw);
		return r;
	endfunction

	// -1 now and then, otherwise any architectural register
	function automatic int rand_reg();
		return ($urandom_range(0, 7) == 0) ? -1 : int'($urandom_range(0, 15));
	endfunction

	function automatic int rand_literal(input op_t op);
		int pick;
		pick = $urandom_range(0, 7);
		if (op == OP_NOP && pick > 0) return $urandom_range(0, 20);
		case (pick)
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 7))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 127;
					3: return 128;
					4: return -128;
					5: return -129;
					6: return 0;
					default: return -1;
				endcase
			end
			2: return $urandom;
			default: return int'($urandom_range(0, 260)) - 130;
		endcase
	endfunction

	function automatic req_t random_req();
		op_t op;
		int  mw;
		op = op_t'($urandom_range(0, 10));
		mw = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) :
			(1 << $urandom_range(0, 3));
		return make_req(op, rand_reg(), rand_reg(), rand_reg(), $urandom_range(0, 3),
			rand_literal(op), $urandom_range(0, 7), $urandom_range(0, 1),
			$urandom_range(0, 1), $urandom_range(0, 1), mw);
	endfunction

	task automatic send_request(input req_t r);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, r.move_width, r.sign_narrow, r.has_displacement, r.wide_operand,
			r.opcode_ext, r.literal_value, r.scale_log2, r.index_reg, r.reg_b, r.reg_a};
		s_tuser  <= r.operation;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic sender_pause();
		if (!quiet && $urandom_range(0, 9) < send_odds) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		int recv_odds;
		recv_odds = 3;
		m_tready <= 1'b0;
		wait (arst_n == 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 9) < recv_odds) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
			if ($urandom_range(0, 63) == 0) recv_odds = $urandom_range(0, 4);
		end
	end

	// watchdog: cycles without any request or result moving
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("x86_64_instruction_encoder_top test failed");
		$finish;
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		arst_n   <= 1'b0;

		// push/pop with and without rex.b, unused register
		directed_q.push_back(make_req(OP_PUSH, 0, -1, -1, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_PUSH, 15, -1, -1, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_POP, -1, -1, -1, 0, 0, 0, 0, 0, 0, 1));
		// rbp base without displacement, r12 base with sib, r13 with disp32
		directed_q.push_back(make_req(OP_MEMBASE, 3, 5, -1, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_MEMBASE, 15, 12, -1, 0, -128, 0, 0, 1, 0, 1));
		directed_q.push_back(make_req(OP_MEMBASE, 7, 13, -1, 0, 32'h7FFFFFFF, 0, 0, 1, 0, 1));
		directed_q.push_back(make_req(OP_MEMSIB, 2, 5, 3, 2, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_MEMSIB, -1, 0, 15, 3, 32'h80000000, 0, 0, 0, 0, 1));
		// self copy is empty, then plain, movsxd, movsx byte, movsx word
		directed_q.push_back(make_req(OP_MOVE, 6, 6, -1, 0, 0, 0, 0, 0, 0, 8));
		directed_q.push_back(make_req(OP_MOVE, -1, 8, -1, 0, 0, 0, 0, 0, 0, 8));
		directed_q.push_back(make_req(OP_MOVE, 10, 3, -1, 0, 0, 0, 0, 0, 1, 4));
		directed_q.push_back(make_req(OP_MOVE, 2, 15, -1, 0, 0, 0, 0, 0, 1, 1));
		directed_q.push_back(make_req(OP_MOVE, 15, 15, -1, 0, 0, 0, 0, 0, 1, 2));
		directed_q.push_back(make_req(OP_SHIFT, 9, -1, -1, 0, -1, 7, 0, 0, 0, 1));
		// lea refusals: rbp-class base, rsp-class index; then a plain sum and an rsp-class base
		directed_q.push_back(make_req(OP_LEASUM, 1, 13, 2, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_LEASUM, 1, 0, 4, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_LEASUM, 15, 8, 9, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_LEADISP, 3, 12, -1, 0, 5, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_LEADISP, -1, 15, -1, 0, -129, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_ALUIMM, 0, -1, -1, 0, -128, 5, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_ALUIMM, 12, -1, -1, 0, 128, 0, 0, 0, 0, 1));
		// nop: empty, saturated, and a 9+6 split
		directed_q.push_back(make_req(OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_NOP, 0, 0, 0, 0, 100, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_NOP, 0, 0, 0, 0, 15, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_REX, -1, -1, -1, 0, 0, 0, 0, 0, 0, 1));
		directed_q.push_back(make_req(OP_REX, 15, 15, 15, 0, 0, 0, 1, 0, 0, 1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) begin
			send_request(directed_q[i]);
			sender_pause();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 32 == 0) send_odds = $urandom_range(0, 4);
			if (i == HOLD_AT) hold_req = 1'b1;
			if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
			send_request(random_req());
			sender_pause();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("x86_64_instruction_encoder_top test passed");
		end else begin
			$display("x86_64_instruction_encoder_top test failed");
		end
		$finish;
	end

endmodule

FILE: x86_64_instruction_encoder_top.f
rtl/core/xenc_pkg.sv
rtl/core/xenc_front.sv
rtl/core/xenc_queue.sv
rtl/core/xenc_back.sv
rtl/core/x86_64_instruction_encoder_top.sv
tb/sv/xenc_encoding_checker.sv
tb/sv/tb_x86_64_instruction_encoder_top.sv
